@@ rtl/opt_pkg.sv @@
// Shared types, constants and helpers for the outstanding packet tracker.
// Used by opt_cell, opt_mod and outstanding_packet_tracker; no dependencies.
package opt_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned CAP_W     = $clog2(ENTRIES + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = $clog2(ID_W);

  localparam int unsigned CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;
  localparam logic [ID_W-1:0] ID_MIN_RESET  = 32'd0;
  localparam logic [ID_W-1:0] ID_MAX_RESET  = 32'd65535;
  localparam logic [ID_W-1:0] ID_SEED_RESET = 32'd0;
  localparam logic [ID_W-1:0] START_RAW_RESET = ID_SEED_RESET % ID_MAX_RESET;
  localparam logic [ID_W-1:0] NEXT_ID_RESET =
      (START_RAW_RESET < ID_MIN_RESET) ? ID_MIN_RESET : START_RAW_RESET;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_ID_MIN   = 2'd1,
    REG_ID_MAX   = 2'd2,
    REG_ID_SEED  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_FROM_PREV = 3'd1,
    CELL_FROM_NEXT = 3'd2,
    CELL_SET_TIME  = 3'd3,
    CELL_CLEAR     = 3'd4
  } cell_cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] packet_seq;
    logic [ID_W-1:0] lookup_id;
    logic [ID_W-1:0] now;
  } opt_in_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] entry_id;
    logic [ID_W-1:0] entry_seq;
    logic [ID_W-1:0] entry_time;
  } opt_out_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] seq;
    logic [ID_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    cell_cmd_e       cmd;
    logic            hit_en;
    logic [ID_W-1:0] lookup_id;
    logic [ID_W-1:0] now;
  } cell_ctl_t;

  // Inclusive prefix OR toward higher indexes, log-depth.
  function automatic logic [ENTRIES-1:0] prefix_or(input logic [ENTRIES-1:0] v);
    logic [ENTRIES-1:0] r;
    r = v;
    for (int s = 1; s < ENTRIES; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

endpackage

@@ rtl/opt_cell.sv @@
// One table cell: holds one entry, ranked by position (cell 0 is newest).
// Shifts to and from its neighbors and registers its id match. Uses opt_pkg.
module opt_cell import opt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  entry_t    prev_i,
  input  entry_t    next_i,
  output entry_t    ent_o,
  output logic      hit_o
);

  logic            valid_q;
  logic [ID_W-1:0] id_q, seq_q, stamp_q;
  entry_t          cur, ent_d;
  logic            hit_q, hit_d;

  assign cur = '{valid: valid_q, id: id_q, seq: seq_q, stamp: stamp_q};

  always_comb begin
    ent_d = cur;
    case (ctl_i.cmd)
      CELL_HOLD:      ent_d = cur;
      CELL_FROM_PREV: ent_d = prev_i;
      CELL_FROM_NEXT: ent_d = next_i;
      CELL_SET_TIME:  ent_d.stamp = ctl_i.now;
      CELL_CLEAR:     ent_d.valid = 1'b0;
      default:        ent_d = cur;
    endcase
  end

  assign hit_d = ctl_i.hit_en ? (cur.valid && (cur.id == ctl_i.lookup_id)) : hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= ent_d.id;
    seq_q   <= ent_d.seq;
    stamp_q <= ent_d.stamp;
  end

  assign ent_o = cur;
  assign hit_o = hit_q;

endmodule

@@ rtl/opt_mod.sv @@
// Start-id unit: seed mod id_max by restoring division, one bit per cycle,
// then raised to id_min. Uses opt_pkg.
module opt_mod import opt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ID_W-1:0] dividend_i,
  input  logic [ID_W-1:0] divisor_i,
  input  logic [ID_W-1:0] min_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [ID_W-1:0] result_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ID_W-1:0]  rem_q, dvd_q;
  logic [ID_W:0]    trial, diff;
  logic             fits;

  assign trial = {rem_q, dvd_q[ID_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(ID_W - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // zero divisor: seed is taken as is
      rem_q <= (divisor_i == '0) ? dividend_i : '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[ID_W-1:0] : trial[ID_W-1:0];
      dvd_q <= dvd_q << 1;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = (rem_q < min_i) ? min_i : rem_q;

endmodule

@@ rtl/outstanding_packet_tracker.sv @@
// Outstanding packet tracker top level: config registers, request sequencer,
// cell chain and id counter. Uses opt_pkg, opt_cell and opt_mod.
//
// Usage: requests enter on in_valid_i/in_stall_o (in_data_i), results leave
// on out_valid_o/out_stall_i (out_data_o), one result per request. Register
// writes go over cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
// The table is a chain of ENTRIES cells ordered newest first: add shifts the
// chain down and drops the oldest when full, remove closes the gap behind the
// newest match, update rewrites one cell's timestamp.
// At the accepting edge each cell registers its id compare; then, in S_EXEC,
// once the output register is free, the newest match is picked, the chain
// moves and the output register is loaded. No new request is taken until
// that is done, and out_valid_o rises when the output register is loaded.
// A write to id_min, id_max or id_seed recomputes the start id with a
// bit-serial remainder unit (skipped when id_max is zero, which takes the
// seed as is); until it is done no request or write is taken.
// A capacity write empties the table at once.
// Reset empties the table and loads the default registers. While the output
// register is stalled, a finished request waits in S_EXEC.
module outstanding_packet_tracker import opt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  opt_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output opt_out_t             out_data_o
);

  state_e           state_q, state_d;
  opt_in_t          req_q;
  logic [CAP_W-1:0] cap_q, cap_wr;
  logic [ID_W-1:0]  id_min_q, id_max_q, id_seed_q, next_id_q;
  logic             reload_q;
  logic             out_valid_q;
  opt_out_t         out_q, out_d;

  logic             in_acc, cfg_acc, go, out_free;
  logic             div_busy, div_done;
  logic [ID_W-1:0]  div_result;
  logic [ID_W:0]    nid_inc;
  logic             nid_wrap;
  logic [4:0]       cap_raw;

  entry_t             ent   [ENTRIES];
  entry_t             prev_e[ENTRIES];
  entry_t             next_e[ENTRIES];
  cell_ctl_t          ctl   [ENTRIES];
  logic [ENTRIES-1:0] hit, after_hit, first;
  entry_t             sel;
  entry_t             new_ent;

  assign in_stall_o  = (state_q != S_IDLE) || reload_q || div_busy;
  assign cfg_ready_o = (state_q == S_IDLE) && !reload_q && !div_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign go          = (state_q == S_EXEC) && out_free;

  // capacity write value: low 5 bits of cfg_data_i, clamped to 1..ENTRIES
  assign cap_raw = cfg_data_i[4:0];
  always_comb begin
    if (cap_raw == 5'd0) begin
      cap_wr = CAP_W'(1);
    end else if (32'(cap_raw) > 32'(ENTRIES)) begin
      cap_wr = CAP_W'(ENTRIES);
    end else begin
      cap_wr = CAP_W'(cap_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_W'(CAP_RESET);
      id_min_q  <= ID_MIN_RESET;
      id_max_q  <= ID_MAX_RESET;
      id_seed_q <= ID_SEED_RESET;
      reload_q  <= 1'b0;
    end else begin
      if (reload_q) begin
        reload_q <= 1'b0;
      end
      if (cfg_acc) begin
        case (reg_idx_e'(cfg_index_i))
          REG_CAPACITY: cap_q <= cap_wr;
          REG_ID_MIN: begin
            id_min_q <= cfg_data_i;
            reload_q <= 1'b1;
          end
          REG_ID_MAX: begin
            id_max_q <= cfg_data_i;
            reload_q <= 1'b1;
          end
          REG_ID_SEED: begin
            id_seed_q <= cfg_data_i;
            reload_q  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  opt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (reload_q),
    .dividend_i (id_seed_q),
    .divisor_i  (id_max_q),
    .min_i      (id_min_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .result_o   (div_result)
  );

  // id counter: loaded from the start-id unit, advances on add, wraps to 1 past id_max or on overflow
  assign nid_inc  = {1'b0, next_id_q} + {{ID_W{1'b0}}, 1'b1};
  assign nid_wrap = nid_inc[ID_W] || (nid_inc[ID_W-1:0] > id_max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q <= NEXT_ID_RESET;
    end else if (div_done) begin
      next_id_q <= div_result;
    end else if (go && (kind_e'(req_q.kind) == KIND_ADD)) begin
      next_id_q <= nid_wrap ? {{(ID_W-1){1'b0}}, 1'b1} : nid_inc[ID_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
  end

  // newest match is the lowest-index hit; cells at or behind it close the gap
  assign after_hit = prefix_or(hit);
  assign first     = hit & ~(after_hit << 1);

  always_comb begin
    sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel = sel | (ent[i] & {$bits(entry_t){first[i]}});
    end
  end

  assign new_ent = '{valid: 1'b1, id: next_id_q, seq: req_q.packet_seq,
                     stamp: req_q.now};

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].hit_en    = in_acc;
      ctl[i].lookup_id = in_data_i.lookup_id;
      ctl[i].now       = req_q.now;
      ctl[i].cmd       = CELL_HOLD;
      if (cfg_acc && (reg_idx_e'(cfg_index_i) == REG_CAPACITY)) begin
        ctl[i].cmd = CELL_CLEAR;
      end else if (go) begin
        case (kind_e'(req_q.kind))
          KIND_ADD: begin
            // drop what would fall past the capacity
            ctl[i].cmd = (CAP_W'(i) < cap_q) ? CELL_FROM_PREV : CELL_CLEAR;
          end
          KIND_UPDATE: if (first[i]) ctl[i].cmd = CELL_SET_TIME;
          KIND_REMOVE: if (after_hit[i]) ctl[i].cmd = CELL_FROM_NEXT;
          KIND_NONE:   ctl[i].cmd = CELL_HOLD;
          default:     ctl[i].cmd = CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_e[g] = new_ent;
    end else begin : g_mid
      assign prev_e[g] = ent[g-1];
    end
    if (g == ENTRIES - 1) begin : g_tail
      assign next_e[g] = '0;
    end else begin : g_body
      assign next_e[g] = ent[g+1];
    end

    opt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .prev_i (prev_e[g]),
      .next_i (next_e[g]),
      .ent_o  (ent[g]),
      .hit_o  (hit[g])
    );
  end

  always_comb begin
    out_d = '0;
    case (kind_e'(req_q.kind))
      KIND_ADD: begin
        out_d.ok         = 1'b1;
        out_d.entry_id   = next_id_q;
        out_d.entry_seq  = req_q.packet_seq;
        out_d.entry_time = req_q.now;
      end
      KIND_UPDATE: out_d.ok = after_hit[ENTRIES-1];
      KIND_REMOVE: begin
        out_d.ok         = after_hit[ENTRIES-1];
        out_d.entry_id   = sel.id;
        out_d.entry_seq  = sel.seq;
        out_d.entry_time = sel.stamp;
      end
      KIND_NONE: out_d = '0;
      default:   out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
